// File: sv/assert_macros.svh
// Assertion macros used by the RTL file ipv4_output_fragmenter.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/ipv4_frag_pkg.sv
// Package for the IPv4 output fragmenter: state and status codes, register
// indexes, header constants and the checksum fold. Depends on nothing.
package ipv4_frag_pkg;

   localparam int MAX_FRAGMENTS = 64;
   localparam logic [15:0] HDR_BYTES = 16'd20;
   localparam logic [7:0] VER_IHL = 8'h45;
   localparam logic [15:0] DF_BIT = 16'h4000;
   localparam logic [15:0] MF_BIT = 16'h2000;

   localparam logic [15:0] LINK_MTU_RESET = 16'd1500;
   localparam logic [7:0] MEDIA_HEADER_RESET = 8'd14;
   localparam logic [15:0] CONN_MAX_FRAG_RESET = 16'd0;

   typedef enum logic [1:0] {
      CSR_LINK_MTU = 2'd0,
      CSR_MEDIA_HEADER = 2'd1,
      CSR_CONN_MAX_FRAG = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      STAT_WHOLE = 3'd0,
      STAT_FRAGMENT = 3'd1,
      STAT_SHORT_GATED = 3'd2,
      STAT_TOO_BIG = 3'd3,
      STAT_DF_SET = 3'd4,
      STAT_SEG_SMALL = 3'd5,
      STAT_TOO_MANY = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_DECIDE,
      ST_COUNT,
      ST_IDENT,
      ST_EMIT,
      ST_DROP
   } state_type;

   // Fold a 20-bit one's-complement sum twice and invert.
   function automatic logic [15:0] csum_fold(input logic [19:0] sum);
      logic [16:0] s1;
      logic [16:0] s2;
      s1 = {1'b0, sum[15:0]} + 17'(sum[19:16]);
      s2 = {1'b0, s1[15:0]} + 17'(s1[16]);
      return ~s2[15:0];
   endfunction

endpackage

// File: sv/ipv4_output_fragmenter.sv
// Top level of the IPv4 output fragmenter: sequencer, checksum unit, id counter.
// Depends on ipv4_frag_pkg and assert_macros.svh.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+-------------------------------
//  req     | in  | req_tvalid / req_tready    | packet descriptor, gating flag
//  rsp     | out | rsp_tvalid / rsp_tready    | header fields, tlast on final
//  csr     | in  | csr_wr_en (no wait)        | link_mtu, media_header, limit
//
// A descriptor is accepted in the idle state, then passes the setup states in order
// (length and limit, decision, id and base sum), with a fragment count check before
// the id state when it must be cut; the emit state then gives the result items in turn,
// or the drop state gives a single discard item. A single checksum adder serves
// every item of the fragment walk. Reset clears the sequencer, the output valid, the
// id counter and the registers to their defaults. A stalled rsp side holds the
// sequencer in its emit or drop state; req_tready is high only when idle.
`include "assert_macros.svh"

module ipv4_output_fragmenter (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // buffer_len[16:0], header_length[32:17], hop_limit[40:33],
   // service_type[48:41], protocol_num[56:49], source_addr[88:57],
   // dest_addr[120:89], ident_in[136:121], frag_word_in[152:137], zero fill
   input  logic [159:0] req_tdata,
   // gating[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], total_length[18:3], ident[34:19], frag_word[50:35],
   // checksum[66:51], payload_start[82:67], zero fill
   output logic [87:0]  rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   // Configuration registers
   logic [15:0] link_mtu_ff;
   logic [7:0] media_header_ff;
   logic [15:0] conn_max_frag_ff;

   // Sequencer state and id counter
   ipv4_frag_pkg::state_type state_ff, state_in;
   logic [15:0] counter_ff, counter_in;

   // Latched descriptor
   logic [16:0] blen_ff;
   logic gating_ff;
   logic [15:0] hlen_ff;
   logic [7:0] ttl_ff, tos_ff, proto_ff;
   logic [31:0] src_ff, dst_ff;
   logic [15:0] idin_ff, fwin_ff;

   // Working registers
   logic [16:0] len_ff, len_in;
   logic signed [17:0] medialen_ff, medialen_in;
   logic [18:0] fixed_sum_ff, fixed_sum_in;
   logic whole_ff, whole_in;
   logic [15:0] seg_ff, seg_in;
   logic [15:0] dlen_ff, dlen_in;
   logic [16:0] off_ff, off_in;
   logic [15:0] lid_ff, lid_in;
   logic [19:0] base_sum_ff, base_sum_in;
   ipv4_frag_pkg::status_type drop_code_ff, drop_code_in;

   // Output register
   logic rsp_valid_ff, rsp_valid_in;
   ipv4_frag_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_tl_ff, rsp_tl_in;
   logic [15:0] rsp_id_ff, rsp_id_in;
   logic [15:0] rsp_fw_ff, rsp_fw_in;
   logic [15:0] rsp_ck_ff, rsp_ck_in;
   logic [15:0] rsp_ps_ff, rsp_ps_in;
   logic rsp_last_ff, rsp_last_in;

   logic req_take;
   logic slot_free;
   logic [15:0] limit;
   logic signed [17:0] seg_room;
   logic fin;
   logic [15:0] piece;
   logic [15:0] emit_tl;
   logic [15:0] emit_fw;
   logic [12:0] emit_off;
   logic [12:0] base_off;
   logic [15:0] mf_keep;
   logic [19:0] emit_sum;
   logic [15:0] new_id;

   assign req_tready = (state_ff == ipv4_frag_pkg::ST_IDLE);
   assign req_take = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         link_mtu_ff <= ipv4_frag_pkg::LINK_MTU_RESET;
         media_header_ff <= ipv4_frag_pkg::MEDIA_HEADER_RESET;
         conn_max_frag_ff <= ipv4_frag_pkg::CONN_MAX_FRAG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ipv4_frag_pkg::CSR_LINK_MTU: link_mtu_ff <= csr_wdata;
            ipv4_frag_pkg::CSR_MEDIA_HEADER: media_header_ff <= csr_wdata[7:0];
            ipv4_frag_pkg::CSR_CONN_MAX_FRAG: conn_max_frag_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Latch the descriptor on acceptance
   always_ff @(posedge clock) begin
      if (req_take) begin
         blen_ff <= req_tdata[16:0];
         hlen_ff <= req_tdata[32:17];
         ttl_ff <= req_tdata[40:33];
         tos_ff <= req_tdata[48:41];
         proto_ff <= req_tdata[56:49];
         src_ff <= req_tdata[88:57];
         dst_ff <= req_tdata[120:89];
         idin_ff <= req_tdata[136:121];
         fwin_ff <= req_tdata[152:137];
         gating_ff <= req_tuser[0];
      end
   end

   // Per-connection limit applies only when nonzero and below the link MTU
   assign limit = (conn_max_frag_ff != 16'd0 && conn_max_frag_ff < link_mtu_ff)
                  ? conn_max_frag_ff : link_mtu_ff;
   assign seg_room = medialen_ff - 18'sd20;

   // Fragment walk: last piece when the next offset reaches the data length
   assign fin = ({1'b0, off_ff} + 18'(seg_ff)) >= 18'(dlen_ff);
   assign piece = fin ? (dlen_ff - off_ff[15:0]) : seg_ff;
   // Forwarded pieces start at the incoming offset and keep its MF on the last
   // piece; local pieces start at zero with MF clear on the last
   assign base_off = gating_ff ? fwin_ff[12:0] : 13'd0;
   assign mf_keep = gating_ff ? (fwin_ff & ipv4_frag_pkg::MF_BIT) : 16'd0;
   assign emit_off = base_off + off_ff[15:3];
   assign emit_tl = whole_ff ? len_ff[15:0] : (piece + ipv4_frag_pkg::HDR_BYTES);
   assign emit_fw = whole_ff ? (gating_ff ? fwin_ff : 16'd0)
                  : ({3'b000, emit_off} | (fin ? mf_keep : ipv4_frag_pkg::MF_BIT));
   // Shared checksum adder: base words plus this item's length and flags
   assign emit_sum = base_sum_ff + 20'(emit_tl) + 20'(emit_fw);
   assign new_id = gating_ff ? idin_ff : (counter_ff + 16'd1);

   always_comb begin
      state_in = state_ff;
      counter_in = counter_ff;
      len_in = len_ff;
      medialen_in = medialen_ff;
      fixed_sum_in = fixed_sum_ff;
      whole_in = whole_ff;
      seg_in = seg_ff;
      dlen_in = dlen_ff;
      off_in = off_ff;
      lid_in = lid_ff;
      base_sum_in = base_sum_ff;
      drop_code_in = drop_code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_tl_in = rsp_tl_ff;
      rsp_id_in = rsp_id_ff;
      rsp_fw_in = rsp_fw_ff;
      rsp_ck_in = rsp_ck_ff;
      rsp_ps_in = rsp_ps_ff;
      rsp_last_in = rsp_last_ff;

      unique case (state_ff)
         ipv4_frag_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = ipv4_frag_pkg::ST_LIMIT;
            end
         end
         ipv4_frag_pkg::ST_LIMIT: begin
            // Length used, medium payload and the fixed header words
            len_in = gating_ff ? {1'b0, hlen_ff} : blen_ff;
            medialen_in = signed'({2'b00, limit}) - signed'({10'd0, media_header_ff});
            fixed_sum_in = 19'({ipv4_frag_pkg::VER_IHL, tos_ff}) + 19'({ttl_ff, proto_ff})
                         + 19'(src_ff[31:16]) + 19'(src_ff[15:0])
                         + 19'(dst_ff[31:16]) + 19'(dst_ff[15:0]);
            state_in = ipv4_frag_pkg::ST_DECIDE;
         end
         ipv4_frag_pkg::ST_DECIDE: begin
            whole_in = 1'b0;
            seg_in = seg_room[15:0] & 16'hfff8;
            dlen_in = len_ff[15:0] - ipv4_frag_pkg::HDR_BYTES;
            if (gating_ff && {1'b0, hlen_ff} > blen_ff) begin
               drop_code_in = ipv4_frag_pkg::STAT_SHORT_GATED;
               state_in = ipv4_frag_pkg::ST_DROP;
            end else if (len_ff[16]) begin
               drop_code_in = ipv4_frag_pkg::STAT_TOO_BIG;
               state_in = ipv4_frag_pkg::ST_DROP;
            end else if (signed'({1'b0, len_ff}) <= medialen_ff) begin
               whole_in = 1'b1;
               state_in = ipv4_frag_pkg::ST_IDENT;
            end else if ((fwin_ff & ipv4_frag_pkg::DF_BIT) != 16'd0) begin
               drop_code_in = ipv4_frag_pkg::STAT_DF_SET;
               state_in = ipv4_frag_pkg::ST_DROP;
            end else if (seg_room < 18'sd8) begin
               drop_code_in = ipv4_frag_pkg::STAT_SEG_SMALL;
               state_in = ipv4_frag_pkg::ST_DROP;
            end else begin
               state_in = ipv4_frag_pkg::ST_COUNT;
            end
         end
         ipv4_frag_pkg::ST_COUNT: begin
            // More pieces than allowed exactly when data exceeds the cap times seg
            if (23'(dlen_ff) > 23'(seg_ff) * 23'(ipv4_frag_pkg::MAX_FRAGMENTS)) begin
               drop_code_in = ipv4_frag_pkg::STAT_TOO_MANY;
               state_in = ipv4_frag_pkg::ST_DROP;
            end else begin
               state_in = ipv4_frag_pkg::ST_IDENT;
            end
         end
         ipv4_frag_pkg::ST_IDENT: begin
            // Take a fresh id for local packets, keep the incoming one for forwarded, fold it into the base sum
            if (!gating_ff) begin
               counter_in = counter_ff + 16'd1;
            end
            lid_in = new_id;
            base_sum_in = {1'b0, fixed_sum_ff} + 20'(new_id);
            off_in = 17'd0;
            state_in = ipv4_frag_pkg::ST_EMIT;
         end
         ipv4_frag_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = whole_ff ? ipv4_frag_pkg::STAT_WHOLE
                                        : ipv4_frag_pkg::STAT_FRAGMENT;
               rsp_tl_in = emit_tl;
               rsp_id_in = lid_ff;
               rsp_fw_in = emit_fw;
               rsp_ck_in = ipv4_frag_pkg::csum_fold(emit_sum);
               rsp_ps_in = whole_ff ? 16'd0 : off_ff[15:0];
               rsp_last_in = whole_ff || fin;
               off_in = off_ff + 17'(seg_ff);
               if (whole_ff || fin) begin
                  state_in = ipv4_frag_pkg::ST_IDLE;
               end
            end
         end
         ipv4_frag_pkg::ST_DROP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = drop_code_ff;
               rsp_tl_in = 16'd0;
               rsp_id_in = 16'd0;
               rsp_fw_in = 16'd0;
               rsp_ck_in = 16'd0;
               rsp_ps_in = 16'd0;
               rsp_last_in = 1'b1;
               state_in = ipv4_frag_pkg::ST_IDLE;
            end
         end
         default: state_in = ipv4_frag_pkg::ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ipv4_frag_pkg::ST_IDLE;
         counter_ff <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         counter_ff <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and output payload
   always_ff @(posedge clock) begin
      len_ff <= len_in;
      medialen_ff <= medialen_in;
      fixed_sum_ff <= fixed_sum_in;
      whole_ff <= whole_in;
      seg_ff <= seg_in;
      dlen_ff <= dlen_in;
      off_ff <= off_in;
      lid_ff <= lid_in;
      base_sum_ff <= base_sum_in;
      drop_code_ff <= drop_code_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tl_ff <= rsp_tl_in;
      rsp_id_ff <= rsp_id_in;
      rsp_fw_ff <= rsp_fw_in;
      rsp_ck_ff <= rsp_ck_in;
      rsp_ps_ff <= rsp_ps_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tdata = {5'd0, rsp_ps_ff, rsp_ck_ff, rsp_fw_ff, rsp_id_ff, rsp_tl_ff,
                       rsp_status_ff};

   // A fragment always carries at least one data byte past the header
   `ASSERT_IMPLIES(a_frag_len, clock, reset, rsp_valid_ff && rsp_status_ff == ipv4_frag_pkg::STAT_FRAGMENT, rsp_tl_ff > ipv4_frag_pkg::HDR_BYTES, "fragment length not above header size")
   // A discard is a single zeroed final item
   `ASSERT_IMPLIES(a_drop_zero, clock, reset, rsp_valid_ff && rsp_status_ff != ipv4_frag_pkg::STAT_WHOLE && rsp_status_ff != ipv4_frag_pkg::STAT_FRAGMENT, rsp_last_ff && rsp_tl_ff == 16'd0 && rsp_ck_ff == 16'd0 && rsp_id_ff == 16'd0, "discard item not zeroed")
   // The id counter only ever steps by one
   `ASSERT_ALWAYS(a_id_step, clock, reset, $past(reset) || counter_ff == $past(counter_ff) || counter_ff == $past(counter_ff) + 16'd1, "id counter jumped")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for ipv4_output_fragmenter: drives packet descriptors,
// predicts every header item and compares them over several link settings.
// Depends on ipv4_frag_pkg and the RTL of the block; reads no files.
module testbench;

   localparam int HEADER_LEN = int'(ipv4_frag_pkg::HDR_BYTES);

   // One packet descriptor as the block sees it on req.
   typedef struct {
      logic [16:0] buffer_len;
      logic        gating;
      logic [15:0] header_length;
      logic [7:0]  hop_limit;
      logic [7:0]  service_type;
      logic [7:0]  protocol_num;
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [15:0] ident_in;
      logic [15:0] frag_word_in;
   } pkt_desc_type;

   // One emitted header item on rsp.
   typedef struct {
      ipv4_frag_pkg::status_type status;
      logic [15:0] total_length;
      logic [15:0] ident;
      logic [15:0] frag_word;
      logic [15:0] checksum;
      logic [15:0] payload_start;
      logic        last;
   } header_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [87:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_wr_en = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_wdata = '0;

   ipv4_output_fragmenter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // buffer_len, header_length, hop_limit, service_type, protocol_num,
      // source_addr, dest_addr, ident_in, frag_word_in, zero fill
      .req_tdata  (req_tdata),
      // gating
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // status, total_length, ident, frag_word, checksum, payload_start, zero fill
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: our own copy of the registers and the id counter.
   logic [15:0] link_mtu_cfg = ipv4_frag_pkg::LINK_MTU_RESET;
   logic [7:0]  media_cfg = ipv4_frag_pkg::MEDIA_HEADER_RESET;
   logic [15:0] conn_limit_cfg = ipv4_frag_pkg::CONN_MAX_FRAG_RESET;
   logic [15:0] ident_ctr = '0;

   pkt_desc_type pkt_pending[$];   // descriptors waiting for the driver
   header_type   hdr_expect[$];    // predicted header items, oldest first
   pkt_desc_type req_cur;          // descriptor currently on req
   bit           req_fired = 1'b0; // req handshake seen at the last rising edge
   bit           steady = 1'b0;    // suppress idling on both sides

   int errors = 0;
   int packets_taken = 0;
   int headers_checked = 0;
   int pieces_predicted = 0;
   int discards_predicted = 0;

   // Payload room of the medium: link MTU or the smaller connection limit,
   // less the media header. May go negative.
   function automatic int media_room();
      if (conn_limit_cfg != 16'd0 && conn_limit_cfg < link_mtu_cfg)
         return int'(conn_limit_cfg) - int'(media_cfg);
      return int'(link_mtu_cfg) - int'(media_cfg);
   endfunction

   function automatic logic [15:0] header_checksum(input pkt_desc_type d,
                                                   input logic [15:0] tl,
                                                   input logic [15:0] id,
                                                   input logic [15:0] fw);
      logic [31:0] s;
      s = {16'd0, ipv4_frag_pkg::VER_IHL, d.service_type} + tl + id + fw
          + {d.hop_limit, d.protocol_num}
          + d.source_addr[31:16] + d.source_addr[15:0]
          + d.dest_addr[31:16] + d.dest_addr[15:0];
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      return ~s[15:0];
   endfunction

   task automatic push_header(input ipv4_frag_pkg::status_type st, input pkt_desc_type d,
                              input logic [15:0] tl, input logic [15:0] id,
                              input logic [15:0] fw, input logic [15:0] ps,
                              input logic last);
      header_type h;
      h.status = st;
      h.total_length = tl;
      h.ident = id;
      h.frag_word = fw;
      h.checksum = header_checksum(d, tl, id, fw);
      h.payload_start = ps;
      h.last = last;
      hdr_expect.push_back(h);
   endtask

   // A dropped packet gives a single item carrying only its status.
   task automatic push_discard(input ipv4_frag_pkg::status_type st);
      header_type h;
      h = '{status: st, total_length: '0, ident: '0, frag_word: '0, checksum: '0,
            payload_start: '0, last: 1'b1};
      hdr_expect.push_back(h);
      discards_predicted++;
   endtask

   // Work out every header item one accepted descriptor causes.
   task automatic fragment_packet(input pkt_desc_type d);
      int len, room, seg, dlen, count, base, off, piece;
      logic [15:0] lid, fw, mf_keep;
      bit fin;
      len = int'(d.buffer_len);
      if (d.gating) begin
         if (d.header_length > d.buffer_len) begin
            push_discard(ipv4_frag_pkg::STAT_SHORT_GATED);
            return;
         end
         len = int'(d.header_length);
      end
      if (len >= 65536) begin
         push_discard(ipv4_frag_pkg::STAT_TOO_BIG);
         return;
      end
      room = media_room();
      if (len <= room) begin
         // Whole packet: forwarded keeps id and flags, local takes a fresh id.
         if (d.gating) begin
            lid = d.ident_in;
            fw = d.frag_word_in;
         end else begin
            ident_ctr = ident_ctr + 16'd1;
            lid = ident_ctr;
            fw = '0;
         end
         push_header(ipv4_frag_pkg::STAT_WHOLE, d, 16'(len), lid, fw, 16'd0, 1'b1);
         return;
      end
      if ((d.frag_word_in & ipv4_frag_pkg::DF_BIT) != 16'd0) begin
         push_discard(ipv4_frag_pkg::STAT_DF_SET);
         return;
      end
      if (room - HEADER_LEN < 8) begin
         push_discard(ipv4_frag_pkg::STAT_SEG_SMALL);
         return;
      end
      seg = (room - HEADER_LEN) & ~7;
      dlen = len - HEADER_LEN;
      count = (dlen + seg - 1) / seg;
      if (count > ipv4_frag_pkg::MAX_FRAGMENTS) begin
         push_discard(ipv4_frag_pkg::STAT_TOO_MANY);
         return;
      end
      if (d.gating) begin
         lid = d.ident_in;
         base = int'(d.frag_word_in[12:0]) << 3;
         mf_keep = d.frag_word_in & ipv4_frag_pkg::MF_BIT;
      end else begin
         ident_ctr = ident_ctr + 16'd1;
         lid = ident_ctr;
         base = 0;
         mf_keep = '0;
      end
      for (int k = 0; k < count; k++) begin
         off = k * seg;
         fin = (off + seg >= dlen);
         piece = fin ? dlen - off : seg;
         // Offset wraps within its 13-bit field; only the final piece keeps MF.
         fw = {3'b000, 13'((base + off) >> 3)};
         fw = fw | (fin ? mf_keep : ipv4_frag_pkg::MF_BIT);
         push_header(ipv4_frag_pkg::STAT_FRAGMENT, d, 16'(piece + HEADER_LEN), lid, fw,
                     16'(off), fin);
         pieces_predicted++;
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("mismatch: %s got %h want %h at header item %0d", field, got, want,
               headers_checked);
   endtask

   task automatic check_header();
      header_type want;
      headers_checked++;
      if (hdr_expect.size() == 0) begin
         report_mismatch("unexpected item, status", 32'(rsp_tdata[2:0]), 32'd0);
         return;
      end
      want = hdr_expect.pop_front();
      if (rsp_tdata[2:0] !== want.status)
         report_mismatch("status", 32'(rsp_tdata[2:0]), 32'(want.status));
      if (rsp_tdata[18:3] !== want.total_length)
         report_mismatch("total_length", 32'(rsp_tdata[18:3]), 32'(want.total_length));
      if (rsp_tdata[34:19] !== want.ident)
         report_mismatch("ident", 32'(rsp_tdata[34:19]), 32'(want.ident));
      if (rsp_tdata[50:35] !== want.frag_word)
         report_mismatch("frag_word", 32'(rsp_tdata[50:35]), 32'(want.frag_word));
      if (rsp_tdata[66:51] !== want.checksum)
         report_mismatch("checksum", 32'(rsp_tdata[66:51]), 32'(want.checksum));
      if (rsp_tdata[82:67] !== want.payload_start)
         report_mismatch("payload_start", 32'(rsp_tdata[82:67]), 32'(want.payload_start));
      if (rsp_tlast !== want.last)
         report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
   endtask

   // Driver: change inputs on the falling edge. Hold valid until the item is
   // taken; idle only between items.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fired) begin
            if (pkt_pending.size() != 0 && (steady || $urandom_range(99) >= 7)) begin
               req_cur = pkt_pending.pop_front();
               req_tdata <= {7'd0, req_cur.frag_word_in, req_cur.ident_in, req_cur.dest_addr,
                             req_cur.source_addr, req_cur.protocol_num, req_cur.service_type,
                             req_cur.hop_limit, req_cur.header_length, req_cur.buffer_len};
               req_tuser <= req_cur.gating;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= 7);
      end
   end

   // Monitor: sample both handshakes on the rising edge; predict on req,
   // check on rsp.
   always @(posedge clock) begin
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         req_fired = req_tvalid && req_tready;
         if (req_fired) begin
            fragment_packet(req_cur);
            packets_taken++;
         end
         if (rsp_tvalid && rsp_tready)
            check_header();
      end
   end

   // Write one register while the block is idle and mirror it in the predictor.
   task automatic write_reg(input ipv4_frag_pkg::csr_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         ipv4_frag_pkg::CSR_LINK_MTU: link_mtu_cfg = val;
         ipv4_frag_pkg::CSR_MEDIA_HEADER: media_cfg = val[7:0];
         ipv4_frag_pkg::CSR_CONN_MAX_FRAG: conn_limit_cfg = val;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_link(input logic [15:0] mtu, input logic [7:0] media,
                           input logic [15:0] limit);
      write_reg(ipv4_frag_pkg::CSR_LINK_MTU, mtu);
      write_reg(ipv4_frag_pkg::CSR_MEDIA_HEADER, {8'd0, media});
      write_reg(ipv4_frag_pkg::CSR_CONN_MAX_FRAG, limit);
   endtask

   // Wait until every item went in and every header came out, then let the
   // sequencer settle before touching registers.
   task automatic wait_idle();
      while (pkt_pending.size() != 0 || req_tvalid || hdr_expect.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic pkt_desc_type make_packet(input int unsigned blen, input bit gated,
                                                input int unsigned hlen,
                                                input logic [15:0] fw);
      pkt_desc_type d;
      d.buffer_len = 17'(blen);
      d.gating = gated;
      d.header_length = 16'(hlen);
      d.hop_limit = 8'($urandom);
      d.service_type = 8'($urandom);
      d.protocol_num = 8'($urandom);
      d.source_addr = $urandom;
      d.dest_addr = $urandom;
      d.ident_in = 16'($urandom);
      d.frag_word_in = fw;
      return d;
   endfunction

   // Mostly packets that fit or cut into a handful of pieces under the current
   // setting; the rest are large packets and every kind of drop.
   function automatic pkt_desc_type random_packet();
      int room, seg, len, pick, n, slack, blen;
      bit gated;
      logic [15:0] fw;
      room = media_room();
      seg = (room - HEADER_LEN >= 8) ? ((room - HEADER_LEN) & ~7) : 0;
      pick = $urandom_range(99);
      gated = $urandom_range(1);
      fw = 16'($urandom) & ~ipv4_frag_pkg::DF_BIT;
      if (pick < 40 && room >= (gated ? 0 : HEADER_LEN)) begin
         len = $urandom_range(room, gated ? 0 : HEADER_LEN);
         if ($urandom_range(2) == 0)
            fw = 16'($urandom);
      end else if (pick < 80 && seg > 0) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 2);
         len = HEADER_LEN + (n - 1) * seg + $urandom_range(seg, 1);
         if (len > 65535)
            len = 65535;
      end else if (pick < 86) begin
         len = $urandom_range(65535, 1000);
      end else if (pick < 91) begin
         blen = $urandom_range(65534, HEADER_LEN);
         return make_packet(blen, 1'b1, $urandom_range(65535, blen + 1), fw);
      end else if (pick < 95) begin
         return make_packet(65536, 1'b0, $urandom_range(65535), fw);
      end else begin
         len = (room < 65535) ? $urandom_range(65535, (room < HEADER_LEN) ? HEADER_LEN
                                                                           : room + 1)
                              : 65535;
         fw = fw | ipv4_frag_pkg::DF_BIT;
      end
      if (gated) begin
         slack = $urandom_range(1) ? 0 : $urandom_range(64);
         if ($urandom_range(19) == 0)
            slack = 65536 - len;
         blen = len + slack;
         if (blen < HEADER_LEN)
            blen = HEADER_LEN;
         return make_packet(blen, 1'b1, len, fw);
      end
      return make_packet(len, 1'b0, $urandom_range(65535), fw);
   endfunction

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++)
         pkt_pending.push_back(random_packet());
   endtask

   initial begin
      pkt_desc_type d;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default link: room 1486, pieces of 1464 bytes.
      set_link(ipv4_frag_pkg::LINK_MTU_RESET, ipv4_frag_pkg::MEDIA_HEADER_RESET,
               ipv4_frag_pkg::CONN_MAX_FRAG_RESET);
      d = make_packet(20, 1'b0, 0, 16'd0);          // smallest local packet, zero fields
      d.hop_limit = '0;
      d.service_type = '0;
      d.protocol_num = '0;
      d.source_addr = '0;
      d.dest_addr = '0;
      d.ident_in = '0;
      pkt_pending.push_back(d);
      d = make_packet(65535, 1'b0, 65535, 16'hbfff); // largest local, fields all ones
      d.hop_limit = '1;
      d.service_type = '1;
      d.protocol_num = '1;
      d.source_addr = '1;
      d.dest_addr = '1;
      d.ident_in = '1;
      pkt_pending.push_back(d);
      pkt_pending.push_back(make_packet(1486, 1'b0, 0, 16'd0));           // fits exactly
      pkt_pending.push_back(make_packet(1487, 1'b0, 0, 16'd0));           // one byte over
      pkt_pending.push_back(make_packet(20, 1'b1, 0, 16'd0));             // zero length header
      pkt_pending.push_back(make_packet(65536, 1'b1, 19, 16'h5a5a));      // short header
      pkt_pending.push_back(make_packet(1486, 1'b1, 1486, 16'hffff));     // flags kept
      pkt_pending.push_back(make_packet(65536, 1'b1, 65535, 16'h3fff));   // offset wraps
      pkt_pending.push_back(make_packet(1487, 1'b1, 1487, ipv4_frag_pkg::MF_BIT)); // MF on last
      pkt_pending.push_back(make_packet(5000, 1'b1, 5000, 16'h0005));
      pkt_pending.push_back(make_packet(100, 1'b1, 101, 16'd0));          // short gated
      pkt_pending.push_back(make_packet(20, 1'b1, 65535, 16'd0));
      pkt_pending.push_back(make_packet(65536, 1'b0, 0, 16'd0));          // too big
      pkt_pending.push_back(make_packet(3000, 1'b0, 0, ipv4_frag_pkg::DF_BIT)); // DF blocks cut
      pkt_pending.push_back(make_packet(3000, 1'b1, 3000, 16'hc000));
      queue_random(40);
      // Hold the sender until every header is back, then resume.
      wait_idle();
      queue_random(40);
      wait_idle();

      // Smallest link: 8-byte pieces, so the fragment ceiling is in reach.
      set_link(16'd28, 8'd0, 16'd0);
      pkt_pending.push_back(make_packet(29, 1'b0, 0, 16'd0));
      pkt_pending.push_back(make_packet(532, 1'b0, 0, 16'd0));            // exactly at ceiling
      pkt_pending.push_back(make_packet(533, 1'b0, 0, 16'd0));            // one piece too many
      pkt_pending.push_back(make_packet(84, 1'b1, 84, 16'h3ffe));
      queue_random(40);
      wait_idle();

      // Room below one 8-byte piece.
      set_link(16'd28, 8'd1, 16'd0);
      pkt_pending.push_back(make_packet(27, 1'b0, 0, 16'd0));
      pkt_pending.push_back(make_packet(28, 1'b0, 0, 16'd0));
      queue_random(20);
      wait_idle();

      // Widest media header under a connection limit; no idling on either side.
      steady = 1'b1;
      set_link(16'hffff, 8'hff, 16'd576);
      queue_random(60);
      wait_idle();
      steady = 1'b0;

      // Connection limit at its top is above the MTU and so ignored.
      set_link(16'd9000, 8'd0, 16'hffff);
      queue_random(50);
      wait_idle();

      // Connection limit below the media header: room is negative.
      set_link(ipv4_frag_pkg::LINK_MTU_RESET, ipv4_frag_pkg::MEDIA_HEADER_RESET, 16'd1);
      pkt_pending.push_back(make_packet(100, 1'b0, 0, 16'd0));
      pkt_pending.push_back(make_packet(20, 1'b1, 0, ipv4_frag_pkg::DF_BIT));
      queue_random(25);
      wait_idle();

      // Widest room: everything fits short of the 64 KiB ceiling.
      set_link(16'hffff, 8'd0, 16'd0);
      queue_random(45);
      wait_idle();

      $display("covered %0d packets on seven link settings: %0d header items checked,",
               packets_taken, headers_checked);
      $display("  %0d of them fragment headers and %0d drops", pieces_predicted,
               discards_predicted);
      if (errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   // Watchdog: far above the slowest correct run.
   initial begin
      #800000;
      $display("timeout: %0d header items still pending", hdr_expect.size());
      $display("testbench: done, errors");
      $finish;
   end

endmodule
